[rtl/bfiq_pkg.sv]
// Package: shared constants, types and the hash building blocks of the Bloom filter.
package bfiq_pkg;

    localparam int unsigned MAX_BITS_DEF   = 65536;
    localparam int unsigned MAX_HASHES_DEF = 16;

    localparam int unsigned NBITS_W = 17;
    localparam int unsigned NHASH_W = 5;
    localparam int unsigned KEY_W   = 64;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 17;

    localparam logic [63:0] SECRET_FLIP = 64'h1cad21f72c81017c ^ 64'hdb979083e96dd4de;
    localparam logic [63:0] MIX_PRIME   = 64'h9FB21C651E98DF69;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_NUM_BITS   = 1'b0,
        CFG_NUM_HASHES = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HPRE,
        ST_HMUL1,
        ST_HMID,
        ST_HMUL2,
        ST_HEND,
        ST_PSTEP,
        ST_MOD,
        ST_RD,
        ST_CHK,
        ST_DONE
    } t_state;

    // 32x32 partial-product request to the shared multiplier
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    // seed term folded with the secret; seed 0 and seed 1 only
    function automatic logic [63:0] seed_flip(input logic seed);
        logic [63:0] s;
        begin
            s = seed ? 64'h0000_0001_0100_0000 ^ 64'h1 ^ 64'h0000_0000_0000_0000 : 64'h0;
            // seed 1: swapped(1)=0x01000000, s = 1 ^ (0x01000000<<32)
            s = seed ? 64'h0100_0000_0000_0001 : 64'h0;
            seed_flip = SECRET_FLIP - s;
        end
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned r);
        rotl = (v << r) | (v >> (64 - r));
    endfunction

endpackage

[rtl/bfiq_mul.sv]
// Shared 32x32 multiplier with registered product.
module bfiq_mul
    import bfiq_pkg::*;
(
    input  logic        i_clk,
    input  t_mul_req    i_req,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_req.a) * 64'(i_req.b);
    end
    assign o_prod = r_prod;
endmodule

[rtl/bfiq_mod.sv]
// Restoring modulo unit: 64-bit value mod a 17-bit divisor, one bit per cycle.
module bfiq_mod
    import bfiq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_num,
    input  logic [NBITS_W-1:0] i_den,
    output logic               o_done,
    output logic [NBITS_W-1:0] o_rem
);
    logic [63:0]        r_num;
    logic [NBITS_W:0]   r_rem;
    logic [6:0]         r_cnt;
    logic               r_busy;
    logic [NBITS_W+1:0] w_sh;
    logic [NBITS_W+1:0] w_df;

    assign w_sh = {r_rem, r_num[63]};
    assign w_df = w_sh - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
            r_num  <= i_num;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= w_df[NBITS_W+1] ? w_sh[NBITS_W:0] : w_df[NBITS_W:0];
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) r_busy <= 1'b0;
        end
    end

    assign o_done = r_busy && (r_cnt == 7'd1);
    assign o_rem  = w_df[NBITS_W+1] ? w_sh[NBITS_W-1:0] : w_df[NBITS_W-1:0];
endmodule

[rtl/bloom_filter_insert_query.sv]
// Top level: Bloom filter with double hashing, sequenced over a shared multiplier.
//
// channel | signals                              | handshake
// --------+--------------------------------------+-----------------------------
// item    | i_start, i_op, i_key / o_busy        | taken when start & !busy
// config  | i_cfg_valid, i_cfg_idx, i_cfg_data   | taken when valid & ready
// result  | o_valid, o_found                     | one-cycle strobe, no stall
//
// Each hash (h1, then h2) runs one load and rotate, two 64-bit multiplies on
// the shared 32x32 multiplier (three partial products; the two cross products
// add only their low halves), one mix step between them and one finish.
// Each probe runs issue, bit-serial modulo, read and check. A query ends right
// after the check of the first clear bit. With zero bits or zero hashes
// configured, an insert or query goes straight to done; op 3 is none.
// Clear sweeps the store one entry per cycle; after reset the same sweep runs
// before the first word. Config is ready only while idle.
// The result strobe comes in the last busy cycle and cannot be stalled.
module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int unsigned MAX_BITS   = MAX_BITS_DEF,
    parameter int unsigned MAX_HASHES = MAX_HASHES_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [OP_W-1:0]      i_op,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_valid,
    output logic                 o_found
);
    localparam int unsigned AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

    // configuration
    logic [NBITS_W-1:0] r_num_bits;
    logic [NHASH_W-1:0] r_num_hashes;
    logic [NBITS_W-1:0] w_m;
    logic [6:0]         w_k;

    // sequencer state
    t_state      r_st, n_st;
    t_op         r_op;
    logic [63:0] r_key;
    logic        r_seed;      // 0 computing h1, 1 computing h2
    logic [63:0] w_pre;       // key halves swapped, folded with the seed term
    logic [63:0] r_h;         // hash working value
    logic [63:0] r_h1, r_h2;
    logic [63:0] r_pos;       // h1 + j*h2
    logic [6:0]  r_j;
    logic [1:0]  r_pp;        // partial product index
    logic [63:0] r_acc;
    logic        r_found;
    logic [AW:0] r_clr;
    logic [AW-1:0] r_addr;

    assign o_cfg_ready = (r_st == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bits   <= '0;
            r_num_hashes <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_BITS:   r_num_bits   <= i_cfg_data;
                CFG_NUM_HASHES: r_num_hashes <= i_cfg_data[NHASH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective modulus and probe count after clamping
    assign w_m = (32'(r_num_bits) > MAX_BITS) ? NBITS_W'(MAX_BITS) : r_num_bits;
    assign w_k = (7'(r_num_hashes) > 7'(MAX_HASHES)) ? 7'(MAX_HASHES) : 7'(r_num_hashes);

    // bit store
    logic r_mem [MAX_BITS];
    logic r_rd;

    // shared multiplier
    t_mul_req    w_req;
    logic [63:0] w_prod;
    logic [63:0] w_mop;

    assign w_pre = {r_key[31:0], r_key[63:32]} ^ seed_flip(r_seed);

    assign w_mop = r_h;
    always_comb begin
        unique case (r_pp)
            2'd0:    w_req = '{a: w_mop[31:0],  b: MIX_PRIME[31:0]};
            2'd1:    w_req = '{a: w_mop[31:0],  b: MIX_PRIME[63:32]};
            default: w_req = '{a: w_mop[63:32], b: MIX_PRIME[31:0]};
        endcase
    end

    bfiq_mul u_mul (.i_clk(i_clk), .i_req(w_req), .o_prod(w_prod));

    // modulo unit
    logic               w_mstart;
    logic               w_mdone;
    logic [NBITS_W-1:0] w_rem;

    bfiq_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_num(r_pos), .i_den(w_m), .o_done(w_mdone), .o_rem(w_rem)
    );

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_start) begin
                unique case (t_op'(i_op))
                    OP_CLEAR: n_st = ST_CLEAR;
                    OP_NONE:  n_st = ST_IDLE;
                    default:  n_st = (w_m == '0 || w_k == '0) ? ST_DONE : ST_HPRE;
                endcase
            end
            ST_CLEAR: if (r_clr == (AW+1)'(MAX_BITS - 1)) n_st = ST_IDLE;
            ST_HPRE:  n_st = ST_HMUL1;
            ST_HMUL1: if (r_pp == 2'd3) n_st = ST_HMID;
            ST_HMID:  n_st = ST_HMUL2;
            ST_HMUL2: if (r_pp == 2'd3) n_st = ST_HEND;
            ST_HEND:  n_st = r_seed ? ST_PSTEP : ST_HPRE;
            ST_PSTEP: n_st = (r_j == w_k) ? ST_DONE : ST_MOD;
            ST_MOD:   if (w_mdone) n_st = ST_RD;
            ST_RD:    n_st = ST_CHK;
            ST_CHK:   n_st = (r_op == OP_QUERY && !r_rd) ? ST_DONE : ST_PSTEP;
            ST_DONE:  n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy   = (r_st != ST_IDLE);
        o_valid  = (r_st == ST_DONE) && (r_op == OP_QUERY);
        o_found  = r_found;
        w_mstart = (r_st == ST_PSTEP) && (r_j != w_k);
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_CLEAR;
            r_clr <= '0;
            r_op  <= OP_NONE;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                ST_IDLE: begin
                    r_op    <= t_op'(i_op);
                    r_key   <= i_key;
                    r_seed  <= 1'b0;
                    r_found <= 1'b0;
                    r_clr   <= '0;
                end
                ST_CLEAR: r_clr <= r_clr + 1'b1;
                ST_HPRE: begin
                    // rotate-xor ahead of the first multiply
                    r_h  <= w_pre ^ rotl(w_pre, 49) ^ rotl(w_pre, 24);
                    r_pp <= 2'd0;
                end
                ST_HMUL1, ST_HMUL2: begin
                    if (r_pp == 2'd0) r_acc <= '0;
                    r_pp <= r_pp + 2'd1;
                    // product of request issued last cycle arrives now
                    if (r_pp == 2'd1) r_acc <= w_prod;
                    if (r_pp == 2'd2) r_acc <= r_acc + {w_prod[31:0], 32'h0};
                    if (r_pp == 2'd3) r_acc <= r_acc + {w_prod[31:0], 32'h0};
                end
                ST_HMID: begin
                    r_h  <= r_acc ^ ((r_acc >> 35) + 64'd8);
                    r_pp <= 2'd0;
                end
                ST_HEND: begin
                    if (r_seed) begin
                        r_h2  <= r_acc ^ (r_acc >> 28);
                        r_pos <= r_h1;
                        r_j   <= '0;
                        r_found <= 1'b1;
                    end else begin
                        r_h1 <= r_acc ^ (r_acc >> 28);
                    end
                    r_seed <= 1'b1;
                end
                ST_MOD: if (w_mdone) r_addr <= AW'(w_rem);
                ST_CHK: begin
                    r_pos <= r_pos + r_h2;
                    r_j   <= r_j + 7'd1;
                    if (!r_rd) r_found <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_CLEAR) begin
            r_mem[r_clr[AW-1:0]] <= 1'b0;
        end else if (r_st == ST_CHK && r_op == OP_INSERT) begin
            r_mem[r_addr] <= 1'b1;
        end
        r_rd <= r_mem[r_addr];
    end
endmodule

[sim/bloom_filter_insert_query_tb.sv]
// Testbench: Bloom filter insert/query/clear against an in-bench filter model.
module bloom_filter_insert_query_tb;
    import bfiq_pkg::*;

    localparam int unsigned STORE_SZ   = 65536;
    localparam int unsigned HASH_CAP   = 16;
    localparam int unsigned CYCLE_MAX  = 10000000;
    localparam logic [63:0] SEED1_TERM = 64'h0100_0000_0000_0001;

    typedef enum logic { ROW_WORD, ROW_REG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_op         op;
        logic [63:0] key;
        t_cfg_idx    idx;
        logic [16:0] data;
        bit          typed;
        bit          found;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic [OP_W-1:0]      i_op;
    logic [KEY_W-1:0]     i_key;
    logic                 o_busy;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 o_valid;
    logic                 o_found;

    // filter model state
    bit          filt_bits [STORE_SZ];
    logic [16:0] reg_bits;
    logic [4:0]  reg_hashes;
    bit          found_q [$];
    logic [63:0] key_pool [$];
    int          errors;
    int unsigned cycles;
    bit          no_idle;
    t_row        rows [$];

    bloom_filter_insert_query uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // global watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_MAX) begin
            $display("FAIL bloom_filter_insert_query");
            $finish;
        end
    end

    // result checker: strobe cannot be stalled, so compare every valid cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (found_q.size() == 0) begin
                $display("%0t: unexpected word, expected none actual found=%0b",
                         $time, o_found);
                errors++;
            end else begin
                if (o_found !== found_q[0]) begin
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $time, found_q[0], o_found);
                    errors++;
                end
                void'(found_q.pop_front());
            end
        end
    end

    // 64-bit XXH3-style hash of an 8-byte key with MIX_PRIME, seed 0 or 1
    function automatic logic [63:0] xxh_key8(logic [63:0] key, bit seed);
        logic [63:0] h;
        h = ({key[31:0], 32'h0} + {32'h0, key[63:32]}) ^
            (SECRET_FLIP - (seed ? SEED1_TERM : 64'h0));
        h = h ^ {h[14:0], h[63:15]} ^ {h[39:0], h[63:40]};
        h = h * MIX_PRIME;
        h = h ^ ((h >> 35) + 64'd8);
        h = h * MIX_PRIME;
        h = h ^ (h >> 28);
        return h;
    endfunction

    // apply one word to the model; returns 1 when a query result is due
    function automatic bit filter_apply(t_op op, logic [63:0] key, output bit found);
        logic [63:0] m, k, h1, h2, pos;
        found = 1'b0;
        m = (reg_bits > STORE_SZ) ? 64'(STORE_SZ) : 64'(reg_bits);
        k = (reg_hashes > HASH_CAP) ? 64'(HASH_CAP) : 64'(reg_hashes);
        if (op == OP_CLEAR) begin
            foreach (filt_bits[i]) filt_bits[i] = 1'b0;
            return 1'b0;
        end
        if (op == OP_NONE) return 1'b0;
        if (m == 0 || k == 0) return (op == OP_QUERY);
        h1 = xxh_key8(key, 1'b0);
        h2 = xxh_key8(key, 1'b1);
        found = 1'b1;
        for (logic [63:0] j = 0; j < k; j++) begin
            pos = (h1 + j * h2) % m;
            if (op == OP_INSERT) begin
                filt_bits[pos] = 1'b1;
            end else if (!filt_bits[pos]) begin
                found = 1'b0;
                break;
            end
        end
        return (op == OP_QUERY);
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // wait until the block is idle and nothing is outstanding
    task automatic drain();
        repeat (2) @(posedge i_clk);
        while (found_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [16:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == CFG_NUM_BITS) reg_bits = data;
        else reg_hashes = data[4:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // issue one word; typed expectation overrides the model's answer
    task automatic send_word(t_op op, logic [63:0] key, bit typed, bit typed_found);
        bit f;
        while (!no_idle && $urandom_range(99) < 30) @(negedge i_clk);
        @(negedge i_clk);
        i_start <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        if (filter_apply(op, key, f)) found_q.push_back(typed ? typed_found : f);
        if (op == OP_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > 64) void'(key_pool.pop_front());
        end
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic add_word(t_op op, logic [63:0] key, bit typed = 0, bit found = 0);
        t_row r;
        r.kind = ROW_WORD; r.op = op; r.key = key; r.typed = typed; r.found = found;
        r.idx = CFG_NUM_BITS; r.data = '0;
        rows.push_back(r);
    endtask

    task automatic add_reg(t_cfg_idx idx, logic [16:0] data);
        t_row r;
        r.kind = ROW_REG; r.idx = idx; r.data = data;
        r.op = OP_NONE; r.key = '0; r.typed = 0; r.found = 0;
        rows.push_back(r);
    endtask

    task automatic random_phase(logic [16:0] nb, logic [4:0] nh, int count, bit quiet);
        t_op op;
        logic [63:0] key;
        int pick;
        drain();
        write_reg(CFG_NUM_BITS, nb);
        write_reg(CFG_NUM_HASHES, nh);
        no_idle = quiet;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(999);
            if (pick < 2)        op = OP_CLEAR;      // each clear sweeps the whole store
            else if (pick < 15)  op = OP_NONE;
            else if (pick < 480) op = OP_INSERT;
            else                 op = OP_QUERY;
            key = rand_key();
            // mostly look up keys already inserted, some one bit off
            if (op == OP_QUERY && key_pool.size() != 0 && $urandom_range(99) < 55) begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
                if ($urandom_range(99) < 20) key[$urandom_range(63)] ^= 1'b1;
            end
            send_word(op, key, 1'b0, 1'b0);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_op        = OP_NONE;
        i_key       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_idx   = CFG_NUM_BITS;
        i_cfg_data  = '0;
        errors      = 0;
        cycles      = 0;
        no_idle     = 1'b0;
        reg_bits    = '0;
        reg_hashes  = '0;
        foreach (filt_bits[i]) filt_bits[i] = 1'b0;

        // directed table: empty filter, codes, extremes, oversized registers
        add_word(OP_QUERY,  64'h0, 1, 0);
        add_word(OP_INSERT, '1);
        add_word(OP_QUERY,  '1, 1, 0);
        add_reg(CFG_NUM_BITS, 17'd1024);
        add_word(OP_QUERY,  64'h0, 1, 0);
        add_reg(CFG_NUM_HASHES, 17'd3);
        add_word(OP_INSERT, 64'h0);
        add_word(OP_QUERY,  64'h0, 1, 1);
        add_word(OP_QUERY,  '1);
        add_word(OP_NONE,   '1);
        add_word(OP_INSERT, '1);
        add_word(OP_QUERY,  '1, 1, 1);
        add_word(OP_CLEAR,  64'h0);
        add_word(OP_QUERY,  64'h0, 1, 0);
        add_reg(CFG_NUM_BITS, 17'd1);
        add_word(OP_INSERT, 64'h5);
        add_word(OP_QUERY,  64'd123, 1, 1);
        add_reg(CFG_NUM_BITS, 17'h1ffff);
        add_reg(CFG_NUM_HASHES, 17'd31);
        add_word(OP_INSERT, 64'h8000_0000_0000_0001);
        add_word(OP_QUERY,  64'h8000_0000_0000_0001, 1, 1);
        add_word(OP_QUERY,  64'h7fff_ffff_ffff_fffe);
        add_reg(CFG_NUM_BITS, 17'd65536);
        add_reg(CFG_NUM_HASHES, 17'd16);
        add_word(OP_INSERT, '1);
        add_word(OP_QUERY,  '1, 1, 1);
        add_word(OP_QUERY,  64'h0123_4567_89ab_cdef);
        add_reg(CFG_NUM_BITS, 17'd0);
        add_word(OP_QUERY,  '1, 1, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // reset runs a clearing sweep first
        drain();

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_REG) begin
                drain();
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                send_word(rows[r].op, rows[r].key, rows[r].typed, rows[r].found);
            end
        end

        // random part, mostly few probes to keep the run short
        random_phase(17'd4096,  5'd3,  300, 1'b0);
        random_phase(17'd256,   5'd2,  250, 1'b1);
        random_phase(17'd65536, 5'd4,  300, 1'b0);
        random_phase(17'($urandom_range(1, 65536)), 5'($urandom_range(1, 6)), 300, 1'b0);
        random_phase(17'd97,    5'd1,  200, 1'b0);
        random_phase(17'($urandom_range(65537, 131071)), 5'd5, 200, 1'b0);
        random_phase(17'd1000,  5'd16,  40, 1'b0);
        random_phase(17'd2048,  5'd20,  30, 1'b0);
        random_phase(17'd512,   5'd0,   30, 1'b0);
        random_phase(17'($urandom_range(8, 8192)), 5'($urandom_range(2, 8)), 100, 1'b0);

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS bloom_filter_insert_query");
        end else begin
            $display("FAIL bloom_filter_insert_query");
        end
        $finish;
    end

endmodule
